FILE: hdl/sstq_pkg.sv
// Shared types and constants for the sorted sleep-timer queue.
`default_nettype none
package sstq_pkg;

    localparam int WAKE_W    = 40;
    localparam int TIME_W    = 32;
    localparam int SECS_W    = 16;
    localparam int ID_PORT_W = 8;
    localparam int USEC_W    = 20;
    localparam int PROD_W    = SECS_W - 1 + USEC_W;
    localparam int ID_MAX_W  = 16;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

    typedef enum logic [2:0] {
        KIND_QUEUED  = 3'd0,
        KIND_ZERO    = 3'd1,
        KIND_INVALID = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_WOKEN   = 3'd4,
        KIND_NONE    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_INS,
        S_TICK
    } t_state;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

    typedef struct packed {
        logic valid;
        logic ge;
        logic due;
    } t_cell_flags;

endpackage
`default_nettype wire

FILE: hdl/sstq_cell.sv
// One queue cell: holds a wake time and id, shifts in on insert, shifts out on pop.
`default_nettype none
module sstq_cell import sstq_pkg::*; #(
    parameter int ID_WIDTH = 8
) (
    input  wire  logic                i_clk,
    input  wire  logic                i_rst_n,
    input  wire  t_cell_ctl           i_ctl,
    input  wire  logic [WAKE_W-1:0]   i_new_wake,
    input  wire  logic [ID_WIDTH-1:0] i_new_id,
    input  wire  logic [WAKE_W-1:0]   i_now,
    input  wire  logic                i_prev_valid,
    input  wire  logic                i_prev_ge,
    input  wire  logic [WAKE_W-1:0]   i_prev_wake,
    input  wire  logic [ID_WIDTH-1:0] i_prev_id,
    input  wire  logic                i_next_valid,
    input  wire  logic [WAKE_W-1:0]   i_next_wake,
    input  wire  logic [ID_WIDTH-1:0] i_next_id,
    output t_cell_flags               o_flags,
    output logic [WAKE_W-1:0]         o_wake,
    output logic [ID_WIDTH-1:0]       o_id
);

    logic                r_valid, n_valid;
    logic [WAKE_W-1:0]   r_wake, n_wake;
    logic [ID_WIDTH-1:0] r_id, n_id;
    logic                ge;

    // empty cells count as later than any new entry
    assign ge = !r_valid || (r_wake >= i_new_wake);

    always_comb begin
        n_valid = r_valid;
        n_wake  = r_wake;
        n_id    = r_id;
        if (i_ctl.pop) begin
            n_valid = i_next_valid;
            n_wake  = i_next_wake;
            n_id    = i_next_id;
        end else if (i_ctl.insert && ge) begin
            if (i_prev_ge) begin
                n_valid = i_prev_valid;
                n_wake  = i_prev_wake;
                n_id    = i_prev_id;
            end else begin
                n_valid = 1'b1;
                n_wake  = i_new_wake;
                n_id    = i_new_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wake <= n_wake;
        r_id   <= n_id;
    end

    assign o_flags.valid = r_valid;
    assign o_flags.ge    = ge;
    assign o_flags.due   = r_valid && (r_wake <= i_now);
    assign o_wake        = r_wake;
    assign o_id          = r_id;

endmodule
`default_nettype wire

FILE: hdl/sorted_sleep_timer_queue.sv
// Top level of the sorted sleep-timer queue: control, wake-time datapath and cell chain.
// Timing: a beat is taken when start is high and busy is low. Negative, zero or
// queue-full sleep requests answer in the next cycle and leave busy low. A queued
// sleep request holds busy through the wake-time add and then the insert into the
// cell chain, and answers in the cycle after the insert. A tick holds busy in
// S_TICK until no further entry is due, at least for the first look, since the
// head of the chain pops one entry per cycle; its results come one per cycle,
// each registered out of S_TICK. Every result is on the output ports for one
// cycle with o_valid high, and the receiver cannot stall it. No clearing pass
// after reset: the queue is empty as soon as reset is released.
`default_nettype none
module sorted_sleep_timer_queue import sstq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  wire  logic                   i_clk,
    input  wire  logic                   i_rst_n,
    input  wire  logic                   start,
    output logic                         busy,
    input  wire  logic                   i_operation,
    input  wire  logic [ID_PORT_W-1:0]   i_requester_id,
    input  wire  logic signed [SECS_W-1:0] i_sleep_seconds,
    input  wire  logic [TIME_W-1:0]      i_current_time,
    output logic                         o_valid,
    output logic [2:0]                   o_kind,
    output logic [ID_PORT_W-1:0]         o_woken_id,
    output logic                         o_last
);

    t_state              r_state, n_state;
    logic                r_first, n_first;
    logic                r_strobe, n_strobe;
    t_kind               r_kind, n_kind;
    logic [ID_PORT_W-1:0] r_woken_id, n_woken_id;
    logic                r_last, n_last;

    logic [TIME_W-1:0]   r_now;
    logic [PROD_W-1:0]   r_prod;
    logic [WAKE_W-1:0]   r_wake;
    logic [ID_WIDTH-1:0] r_id;

    logic                accept;
    logic                secs_neg, secs_zero, full;
    logic [PROD_W-1:0]   prod;
    logic [ID_MAX_W-1:0] in_id_wide, out_id_wide;
    logic [WAKE_W-1:0]   now_wide;
    t_cell_ctl           ctl;

    t_cell_flags         cell_flags [QUEUE_DEPTH];
    logic [WAKE_W-1:0]   cell_wake  [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] cell_id    [QUEUE_DEPTH];

    assign accept     = start && !busy;
    assign secs_neg   = i_sleep_seconds[SECS_W-1];
    assign secs_zero  = (i_sleep_seconds == '0);
    assign full       = cell_flags[QUEUE_DEPTH-1].valid;
    assign prod       = PROD_W'(i_sleep_seconds[SECS_W-2:0]) * PROD_W'(USEC_PER_SEC);
    assign in_id_wide = ID_MAX_W'(i_requester_id);
    assign out_id_wide = ID_MAX_W'(cell_id[0]);
    assign now_wide   = WAKE_W'(r_now);

    always_comb begin
        n_state    = r_state;
        n_first    = r_first;
        n_strobe   = 1'b0;
        n_kind     = KIND_NONE;
        n_woken_id = '0;
        n_last     = 1'b1;
        ctl        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation) begin
                        n_state = S_TICK;
                        n_first = 1'b1;
                    end else if (secs_neg) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_INVALID;
                    end else if (secs_zero) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_ZERO;
                    end else if (full) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_FULL;
                    end else begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD: begin
                n_state = S_INS;
            end
            S_INS: begin
                ctl.insert = 1'b1;
                n_strobe   = 1'b1;
                n_kind     = KIND_QUEUED;
                n_state    = S_IDLE;
            end
            S_TICK: begin
                n_first  = 1'b0;
                n_strobe = 1'b1;
                if (cell_flags[0].due) begin
                    ctl.pop    = 1'b1;
                    n_kind     = KIND_WOKEN;
                    n_woken_id = out_id_wide[ID_PORT_W-1:0];
                    n_last     = !cell_flags[1].due;
                    if (!cell_flags[1].due) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    // nothing due on the first look
                    n_kind  = KIND_NONE;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_first  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_first  <= n_first;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_woken_id <= n_woken_id;
        r_last     <= n_last;
        if (accept && r_state == S_IDLE) begin
            r_now  <= i_current_time;
            r_prod <= prod;
            r_id   <= in_id_wide[ID_WIDTH-1:0];
        end
        if (r_state == S_ADD) begin
            r_wake <= WAKE_W'(r_now) + WAKE_W'(r_prod);
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                prev_valid, prev_ge, next_valid;
            logic [WAKE_W-1:0]   prev_wake, next_wake;
            logic [ID_WIDTH-1:0] prev_id, next_id;

            if (g == 0) begin : g_head
                assign prev_valid = 1'b1;
                assign prev_ge    = 1'b0;
                assign prev_wake  = '0;
                assign prev_id    = '0;
            end else begin : g_body
                assign prev_valid = cell_flags[g-1].valid;
                assign prev_ge    = cell_flags[g-1].ge;
                assign prev_wake  = cell_wake[g-1];
                assign prev_id    = cell_id[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_wake  = '0;
                assign next_id    = '0;
            end else begin : g_mid
                assign next_valid = cell_flags[g+1].valid;
                assign next_wake  = cell_wake[g+1];
                assign next_id    = cell_id[g+1];
            end

            sstq_cell #(
                .ID_WIDTH(ID_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_new_wake  (r_wake),
                .i_new_id    (r_id),
                .i_now       (now_wide),
                .i_prev_valid(prev_valid),
                .i_prev_ge   (prev_ge),
                .i_prev_wake (prev_wake),
                .i_prev_id   (prev_id),
                .i_next_valid(next_valid),
                .i_next_wake (next_wake),
                .i_next_id   (next_id),
                .o_flags     (cell_flags[g]),
                .o_wake      (cell_wake[g]),
                .o_id        (cell_id[g])
            );
        end
    endgenerate

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_strobe;
    assign o_kind     = r_kind;
    assign o_woken_id = r_woken_id;
    assign o_last     = r_last;

endmodule
`default_nettype wire

FILE: hdl/sstq_chk.sv
// Port-level checker for the sorted sleep-timer queue, bound to the top level.
`default_nettype none
module sstq_chk import sstq_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic                     i_operation,
    input wire logic signed [SECS_W-1:0] i_sleep_seconds,
    input wire logic                     o_valid,
    input wire logic [2:0]               o_kind,
    input wire logic [ID_PORT_W-1:0]     o_woken_id,
    input wire logic                     o_last
);

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind <= KIND_NONE))
        else $error("result kind out of range");

    a_neg_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_operation && i_sleep_seconds[SECS_W-1])
        |=> (o_valid && o_kind == KIND_INVALID && o_last))
        else $error("negative sleep not answered as invalid");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation) |=> busy)
        else $error("tick beat did not raise busy");

    a_only_woken_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_kind == KIND_WOKEN))
        else $error("non-final result that is not a wake");

    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_WOKEN) |-> (o_woken_id == '0))
        else $error("id present on a non-wake result");

endmodule

bind sorted_sleep_timer_queue sstq_chk u_sstq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .i_sleep_seconds(i_sleep_seconds),
    .o_valid        (o_valid),
    .o_kind         (o_kind),
    .o_woken_id     (o_woken_id),
    .o_last         (o_last)
);
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the sorted sleep-timer queue: directed and random beats.
`timescale 1ns / 100ps

import sstq_pkg::*;

typedef struct packed {
    t_kind                kind;
    logic [ID_PORT_W-1:0] id;
    logic                 last;
} wake_result_t;

class timer_queue_board;
    int unsigned          depth;
    logic [WAKE_W-1:0]    wake_at[$];
    logic [ID_PORT_W-1:0] sleeper[$];
    wake_result_t         owed[$];
    int unsigned          mismatches;

    function new(int unsigned slots);
        depth      = slots;
        mismatches = 0;
    endfunction

    function void note_request(logic op, logic [ID_PORT_W-1:0] id,
                               logic signed [SECS_W-1:0] secs, logic [TIME_W-1:0] now);
        logic [WAKE_W-1:0] wake;
        wake_result_t      res;
        int unsigned       due;
        int unsigned       slot;
        int unsigned       i;
        if (op) begin
            due = 0;
            while (due < wake_at.size() && wake_at[due] <= WAKE_W'(now))
                due++;
            if (due == 0) begin
                res = '{KIND_NONE, '0, 1'b1};
                owed.push_back(res);
            end
            for (i = 0; i < due; i++) begin
                res = '{KIND_WOKEN, sleeper.pop_front(), (i + 1 == due)};
                void'(wake_at.pop_front());
                owed.push_back(res);
            end
        end else begin
            res = '{KIND_QUEUED, '0, 1'b1};
            if (secs < 0) begin
                res.kind = KIND_INVALID;
            end else if (secs == 0) begin
                res.kind = KIND_ZERO;
            end else if (wake_at.size() >= depth) begin
                res.kind = KIND_FULL;
            end else begin
                // new sleeper goes ahead of equal wake times
                wake = WAKE_W'(now) + WAKE_W'(secs) * WAKE_W'(USEC_PER_SEC);
                slot = 0;
                while (slot < wake_at.size() && wake_at[slot] < wake)
                    slot++;
                wake_at.insert(slot, wake);
                sleeper.insert(slot, id);
            end
            owed.push_back(res);
        end
    endfunction

    function void check_result(t_kind kind, logic [ID_PORT_W-1:0] id, logic last);
        wake_result_t exp;
        if (owed.size() == 0) begin
            $display("%0t: unexpected beat kind %0d id %0d last %0d", $time, kind, id, last);
            mismatches++;
            return;
        end
        exp = owed.pop_front();
        if (exp.kind !== kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d", $time, exp.kind, kind);
            mismatches++;
        end
        if (exp.id !== id) begin
            $display("%0t: woken_id mismatch, expected %0d, actual %0d", $time, exp.id, id);
            mismatches++;
        end
        if (exp.last !== last) begin
            $display("%0t: last mismatch, expected %0d, actual %0d", $time, exp.last, last);
            mismatches++;
        end
    endfunction
endclass

module tb_top;
    localparam int SLOTS = 16;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_operation = 1'b0;
    logic [ID_PORT_W-1:0]     i_requester_id = '0;
    logic signed [SECS_W-1:0] i_sleep_seconds = '0;
    logic [TIME_W-1:0]        i_current_time = '0;
    logic                     o_valid;
    logic [2:0]               o_kind;
    logic [ID_PORT_W-1:0]     o_woken_id;
    logic                     o_last;

    timer_queue_board board = new(SLOTS);
    int unsigned      issued = 0;
    int unsigned      gap_pct = 0;
    logic [TIME_W-1:0] clock_us = '0;

    sorted_sleep_timer_queue #(.QUEUE_DEPTH(SLOTS), .ID_WIDTH(8)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_requester_id  (i_requester_id),
        .i_sleep_seconds (i_sleep_seconds),
        .i_current_time  (i_current_time),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_woken_id      (o_woken_id),
        .o_last          (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result(t_kind'(o_kind), o_woken_id, o_last);
    end

    task automatic issue(input logic op, input logic [ID_PORT_W-1:0] id,
                         input logic signed [SECS_W-1:0] secs,
                         input logic [TIME_W-1:0] now, input bit drain);
        i_operation     <= op;
        i_requester_id  <= id;
        i_sleep_seconds <= secs;
        i_current_time  <= now;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
        board.note_request(op, id, secs, now);
        issued++;
        if (drain || $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            if (drain) begin
                while (board.owed.size() != 0)
                    @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    endtask

    task automatic random_beat();
        int unsigned              pick;
        int unsigned              k;
        logic signed [SECS_W-1:0] secs;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            // burst long enough to hit a full queue
            for (k = 0; k < 17; k++)
                issue(1'b0, ID_PORT_W'($urandom), SECS_W'($urandom_range(1, 4)),
                      clock_us, 1'b0);
        end else if (pick < 55) begin
            issue(1'b0, ID_PORT_W'($urandom), SECS_W'($urandom_range(1, 4)), clock_us, 1'b0);
        end else if (pick < 85) begin
            clock_us = clock_us + $urandom_range(0, 2500000);
            issue(1'b1, ID_PORT_W'($urandom), SECS_W'($urandom), clock_us, 1'b0);
        end else if (pick < 93) begin
            secs = SECS_W'($urandom);
            if ($urandom_range(0, 3) == 0)
                secs = '0;
            if (secs > 0)
                issue(1'b0, ID_PORT_W'($urandom), SECS_W'($urandom_range(1, 600)),
                      clock_us, 1'b0);
            else
                issue(1'b0, ID_PORT_W'($urandom), secs, $urandom, 1'b0);
        end else begin
            issue(1'b1, ID_PORT_W'($urandom), SECS_W'($urandom), $urandom, 1'b0);
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(1'b1, 8'h00, 16'sd0, 32'd0, 1'b0);
        issue(1'b0, 8'h11, -16'sd1, 32'hFFFF_FFFF, 1'b0);
        issue(1'b0, 8'hEE, -16'sd32768, 32'd0, 1'b0);
        issue(1'b0, 8'h22, 16'sd0, 32'd12345, 1'b0);
        issue(1'b0, 8'h00, 16'sd1, 32'd0, 1'b0);
        issue(1'b0, 8'hFF, 16'sd1, 32'd0, 1'b0);
        issue(1'b0, 8'h5A, 16'sd2, 32'd0, 1'b0);
        issue(1'b0, 8'hA5, 16'sd1, 32'd500000, 1'b0);
        issue(1'b1, 8'h00, 16'sd0, 32'd999999, 1'b0);
        issue(1'b1, 8'h00, 16'sd0, 32'd1000000, 1'b0);
        for (k = 0; k < 14; k++)
            issue(1'b0, ID_PORT_W'($urandom), SECS_W'($urandom_range(1, 4)), 32'd0, 1'b0);
        issue(1'b0, 8'h77, 16'sd3, 32'd0, 1'b0);
        issue(1'b1, 8'hFF, -16'sd1, 32'hFFFF_FFFF, 1'b1);
        // largest wake time, beyond any tick: stays at the tail for good
        issue(1'b0, 8'h80, 16'sd32767, 32'hFFFF_FFFF, 1'b0);

        for (phase = 0; phase < 3; phase++) begin
            gap_pct  = (phase == 0) ? 29 : (phase == 1) ? 50 : 0;
            clock_us = $urandom_range(0, 32'hC000_0000);
            while (issued < 25 + 140 * (phase + 1))
                random_beat();
            issue(1'b1, ID_PORT_W'($urandom), SECS_W'($urandom), 32'hFFFF_FFFF, 1'b1);
        end

        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.owed.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: sim.f
hdl/sstq_pkg.sv
hdl/sstq_cell.sv
hdl/sorted_sleep_timer_queue.sv
hdl/sstq_chk.sv
test/tb_top.sv
